// ===== hw/rtl/pf_pkg.sv =====
`timescale 1ns / 1ps

package pf_pkg;

    localparam int LETTER_W = 5;
    localparam int CELL_W   = 5;
    localparam int ROW_W    = 3;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Q = 5'd16;
    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_LAST = 5'd25;

    localparam int LETTERS = 26;
    localparam int CELLS   = 25;
    localparam logic [CELL_W-1:0] CELLS_FULL = 5'd25;
    localparam logic [ROW_W-1:0]  SIDE_LAST  = 3'd4;

    localparam logic [1:0] CMD_KEY      = 2'd0;
    localparam logic [1:0] CMD_KEY_DONE = 2'd1;
    localparam logic [1:0] CMD_TEXT     = 2'd2;
    localparam logic [1:0] CMD_END      = 2'd3;

    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    // filler never equals the letter it splits or pads
    function automatic logic [LETTER_W-1:0] filler_pick(input logic [LETTER_W-1:0] filler,
                                                        input logic [LETTER_W-1:0] l);
        logic [LETTER_W-1:0] f;
        f = (filler > LETTER_LAST) ? LETTER_X : filler;
        f = fold_letter(f);
        if (f == l) begin
            f = (l == LETTER_Q) ? LETTER_X : LETTER_Q;
        end
        return f;
    endfunction

    function automatic logic [ROW_W-1:0] cell_row(input logic [CELL_W-1:0] c);
        logic [ROW_W-1:0] r;
        if (c < 5'd5) r = 3'd0;
        else if (c < 5'd10) r = 3'd1;
        else if (c < 5'd15) r = 3'd2;
        else if (c < 5'd20) r = 3'd3;
        else r = 3'd4;
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                     input logic [ROW_W-1:0] k);
        logic [CELL_W-1:0] r5;
        r5 = {2'b00, r};
        return (r5 << 2) + r5 + {2'b00, k};
    endfunction

    function automatic logic [ROW_W-1:0] cell_col(input logic [CELL_W-1:0] c);
        logic [CELL_W-1:0] d;
        d = c - cell_index(cell_row(c), 3'd0);
        return d[ROW_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] wrap_inc(input logic [ROW_W-1:0] v);
        return (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

// ===== hw/rtl/pf_rule.sv =====
`timescale 1ns / 1ps

// Row, column and rectangle rules: maps the two plaintext cells to cipher cells.
module pf_rule (
    input  logic [pf_pkg::CELL_W-1:0] cell_a,
    input  logic [pf_pkg::CELL_W-1:0] cell_b,
    output logic [pf_pkg::CELL_W-1:0] out_a,
    output logic [pf_pkg::CELL_W-1:0] out_b
);

    logic [pf_pkg::ROW_W-1:0] ra;
    logic [pf_pkg::ROW_W-1:0] ka;
    logic [pf_pkg::ROW_W-1:0] rb;
    logic [pf_pkg::ROW_W-1:0] kb;

    assign ra = pf_pkg::cell_row(cell_a);
    assign ka = pf_pkg::cell_col(cell_a);
    assign rb = pf_pkg::cell_row(cell_b);
    assign kb = pf_pkg::cell_col(cell_b);

    always_comb begin
        if (ra == rb) begin
            out_a = pf_pkg::cell_index(ra, pf_pkg::wrap_inc(ka));
            out_b = pf_pkg::cell_index(rb, pf_pkg::wrap_inc(kb));
        end else if (ka == kb) begin
            out_a = pf_pkg::cell_index(pf_pkg::wrap_inc(ra), ka);
            out_b = pf_pkg::cell_index(pf_pkg::wrap_inc(rb), kb);
        end else begin
            out_a = pf_pkg::cell_index(ra, kb);
            out_b = pf_pkg::cell_index(rb, ka);
        end
    end

endmodule

// ===== hw/rtl/playfair_digraph_encrypt_top.sv =====
`timescale 1ns / 1ps

// Playfair encryptor with a 5x5 key square held in two small single-port
// memories (cell -> letter, letter -> cell). A key letter word leaves the
// block ready. A key-done word runs the fill sweep over the alphabet, one
// letter a cycle, and the block is ready again once it passes the last
// letter. A text letter that opens a pair is held, leaving the block ready;
// one that closes a pair, or an end word that pads one, runs two letter-to-
// cell reads, the rule step and two key-square reads via the single read
// port of each memory, waiting while the output register is held full. Text
// and end words before the square is full are dropped. The last result word
// sits in an output register, so the next word is taken while it waits.
module playfair_digraph_encrypt_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pf_pkg::LETTER_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_cmd,
    input  logic [pf_pkg::LETTER_W-1:0] s_letter,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pf_pkg::LETTER_W-1:0] m_cipher_letter,
    output logic                        m_pair_end
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_LOOKA = 3'd2;
    localparam logic [2:0] ST_LOOKB = 3'd3;
    localparam logic [2:0] ST_CALC  = 3'd4;
    localparam logic [2:0] ST_OUTA  = 3'd5;
    localparam logic [2:0] ST_OUTB  = 3'd6;

    logic [pf_pkg::LETTER_W-1:0] key_square [pf_pkg::CELLS];
    logic [pf_pkg::CELL_W-1:0]   letter_cell [pf_pkg::LETTERS];

    logic [2:0]                  state_reg, state_next;
    logic [pf_pkg::LETTER_W-1:0] filler_letter_reg;
    logic [pf_pkg::LETTERS-1:0]  letter_used_reg, letter_used_next;
    logic [pf_pkg::CELL_W-1:0]   cells_filled_reg, cells_filled_next;
    logic [pf_pkg::LETTER_W-1:0] pending_letter_reg, pending_letter_next;
    logic                        pending_valid_reg, pending_valid_next;
    logic [pf_pkg::LETTER_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [pf_pkg::LETTER_W-1:0] a_reg, a_next;
    logic [pf_pkg::LETTER_W-1:0] b_reg, b_next;
    logic [pf_pkg::CELL_W-1:0]   ca_reg, ca_next;
    logic [pf_pkg::CELL_W-1:0]   ob_reg, ob_next;
    logic                        m_valid_reg, m_valid_next;
    logic [pf_pkg::LETTER_W-1:0] m_cipher_letter_reg, m_cipher_letter_next;
    logic                        m_pair_end_reg, m_pair_end_next;

    logic [pf_pkg::CELL_W-1:0]   lc_rd_reg;
    logic [pf_pkg::LETTER_W-1:0] ks_rd_reg;

    logic                        lc_ren;
    logic [pf_pkg::LETTER_W-1:0] lc_raddr;
    logic                        ks_ren;
    logic [pf_pkg::CELL_W-1:0]   ks_raddr;
    logic                        place_req;
    logic                        place_en;
    logic [pf_pkg::LETTER_W-1:0] place_letter;
    logic                        accept;
    logic                        out_free;
    logic                        sq_full;
    logic [pf_pkg::LETTER_W-1:0] in_fold;
    logic                        in_ok;
    logic [pf_pkg::CELL_W-1:0]   rule_oa;
    logic [pf_pkg::CELL_W-1:0]   rule_ob;

    pf_rule u_rule (
        .cell_a (ca_reg),
        .cell_b (lc_rd_reg),
        .out_a  (rule_oa),
        .out_b  (rule_ob)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign accept          = s_valid && s_ready;
    assign out_free        = !m_valid_reg || m_ready;
    assign sq_full         = (cells_filled_reg == pf_pkg::CELLS_FULL);
    assign in_fold         = pf_pkg::fold_letter(s_letter);
    assign in_ok           = (s_letter <= pf_pkg::LETTER_LAST);
    assign m_valid         = m_valid_reg;
    assign m_cipher_letter = m_cipher_letter_reg;
    assign m_pair_end      = m_pair_end_reg;

    // placement of one letter at the next free cell
    always_comb begin
        place_req    = 1'b0;
        place_letter = in_fold;
        if (state_reg == ST_FILL) begin
            place_letter = fill_cnt_reg;
            place_req    = (fill_cnt_reg != pf_pkg::LETTER_J);
        end else if (accept && s_cmd == pf_pkg::CMD_KEY) begin
            place_req = in_ok;
        end
        place_en = place_req && !letter_used_reg[place_letter] && !sq_full;
    end

    always_comb begin
        state_next           = state_reg;
        letter_used_next     = letter_used_reg;
        cells_filled_next    = cells_filled_reg;
        pending_letter_next  = pending_letter_reg;
        pending_valid_next   = pending_valid_reg;
        fill_cnt_next        = fill_cnt_reg;
        a_next               = a_reg;
        b_next               = b_reg;
        ca_next              = ca_reg;
        ob_next              = ob_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        m_cipher_letter_next = m_cipher_letter_reg;
        m_pair_end_next      = m_pair_end_reg;
        lc_ren               = 1'b0;
        lc_raddr             = a_reg;
        ks_ren               = 1'b0;
        ks_raddr             = rule_oa;

        if (place_en) begin
            letter_used_next[place_letter] = 1'b1;
            cells_filled_next              = cells_filled_reg + 5'd1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        pf_pkg::CMD_KEY: begin
                        end
                        pf_pkg::CMD_KEY_DONE: begin
                            fill_cnt_next = '0;
                            state_next    = ST_FILL;
                        end
                        pf_pkg::CMD_TEXT: begin
                            if (in_ok && sq_full) begin
                                if (!pending_valid_reg) begin
                                    pending_letter_next = in_fold;
                                    pending_valid_next  = 1'b1;
                                end else begin
                                    a_next     = pending_letter_reg;
                                    state_next = ST_LOOKA;
                                    // doubled letter: the repeat opens the next pair
                                    if (pending_letter_reg == in_fold) begin
                                        b_next = pf_pkg::filler_pick(filler_letter_reg,
                                                                     in_fold);
                                    end else begin
                                        b_next             = in_fold;
                                        pending_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        pf_pkg::CMD_END: begin
                            if (sq_full && pending_valid_reg) begin
                                a_next = pending_letter_reg;
                                b_next = pf_pkg::filler_pick(filler_letter_reg,
                                                             pending_letter_reg);
                                pending_valid_next = 1'b0;
                                state_next         = ST_LOOKA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                fill_cnt_next = fill_cnt_reg + 5'd1;
                if (fill_cnt_reg == pf_pkg::LETTER_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKA: begin
                lc_ren     = 1'b1;
                lc_raddr   = a_reg;
                state_next = ST_LOOKB;
            end
            ST_LOOKB: begin
                ca_next    = lc_rd_reg;
                lc_ren     = 1'b1;
                lc_raddr   = b_reg;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                ks_ren     = 1'b1;
                ks_raddr   = rule_oa;
                ob_next    = rule_ob;
                state_next = ST_OUTA;
            end
            ST_OUTA: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_cipher_letter_next = ks_rd_reg;
                    m_pair_end_next      = 1'b0;
                    ks_ren               = 1'b1;
                    ks_raddr             = ob_reg;
                    state_next           = ST_OUTB;
                end
            end
            ST_OUTB: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_cipher_letter_next = ks_rd_reg;
                    m_pair_end_next      = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            filler_letter_reg  <= pf_pkg::LETTER_X;
            letter_used_reg    <= '0;
            cells_filled_reg   <= '0;
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
            fill_cnt_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            if (cfg_wr_en) begin
                filler_letter_reg <= cfg_wr_data;
            end
            letter_used_reg    <= letter_used_next;
            cells_filled_reg   <= cells_filled_next;
            pending_letter_reg <= pending_letter_next;
            pending_valid_reg  <= pending_valid_next;
            fill_cnt_reg       <= fill_cnt_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg               <= a_next;
        b_reg               <= b_next;
        ca_reg              <= ca_next;
        ob_reg              <= ob_next;
        m_cipher_letter_reg <= m_cipher_letter_next;
        m_pair_end_reg      <= m_pair_end_next;
    end

    // key square and its inverse map
    always_ff @(posedge aclk) begin
        if (place_en) begin
            key_square[cells_filled_reg] <= place_letter;
            letter_cell[place_letter]    <= cells_filled_reg;
        end
        if (lc_ren) begin
            lc_rd_reg <= letter_cell[lc_raddr];
        end
        if (ks_ren) begin
            ks_rd_reg <= key_square[ks_raddr];
        end
    end

endmodule

// ===== tb/sv/playfair_digraph_encrypt_top_test.sv =====
`timescale 1ns / 1ps

module playfair_digraph_encrypt_top_test;
    import pf_pkg::*;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [LETTER_W-1:0] letter;
    } word_t;

    typedef struct packed {
        logic [LETTER_W-1:0] code;
        logic                pair_end;
    } cipher_t;

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [LETTER_W-1:0] cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [1:0]          s_cmd       = CMD_KEY;
    logic [LETTER_W-1:0] s_letter    = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [LETTER_W-1:0] m_cipher_letter;
    logic                m_pair_end;

    playfair_digraph_encrypt_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_letter        (s_letter),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_letter (m_cipher_letter),
        .m_pair_end      (m_pair_end)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // stimulus and expected ciphertext
    word_t   word_q[$];
    cipher_t cipher_q[$];
    int      words_left = 0;
    int      mismatches = 0;
    bit      calm       = 1'b0;
    int      send_gap   = 0;
    int      stall_left = 0;
    word_t   next_word;

    // shadow of the key square and pairing state
    logic [LETTER_W-1:0] square [CELLS];
    logic [LETTER_W-1:0] cell_of [LETTERS];
    logic [LETTERS-1:0]  placed      = '0;
    int                  filled      = 0;
    logic [LETTER_W-1:0] open_letter = '0;
    logic                open_valid  = 1'b0;
    logic [LETTER_W-1:0] filler_reg  = LETTER_X;

    function automatic logic [LETTER_W-1:0] as_i(input logic [LETTER_W-1:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    function automatic void place_letter(input logic [LETTER_W-1:0] l);
        if (l > LETTER_LAST || filled >= CELLS || placed[l]) return;
        square[filled] = l;
        cell_of[l] = 5'(filled);
        placed[l] = 1'b1;
        filled++;
    endfunction

    function automatic logic [LETTER_W-1:0] pad_for(input logic [LETTER_W-1:0] l);
        logic [LETTER_W-1:0] f;
        f = (filler_reg > LETTER_LAST) ? LETTER_X : filler_reg;
        f = as_i(f);
        if (f == l) f = (l == LETTER_Q) ? LETTER_X : LETTER_Q;
        return f;
    endfunction

    function automatic void push_pair(input logic [LETTER_W-1:0] a,
                                      input logic [LETTER_W-1:0] b);
        int ca, cb, ra, rb, ka, kb, oa, ob;
        ca = cell_of[a];
        cb = cell_of[b];
        ra = ca / 5;
        ka = ca % 5;
        rb = cb / 5;
        kb = cb % 5;
        if (ra == rb) begin
            oa = ra * 5 + (ka + 1) % 5;
            ob = rb * 5 + (kb + 1) % 5;
        end else if (ka == kb) begin
            oa = ((ra + 1) % 5) * 5 + ka;
            ob = ((rb + 1) % 5) * 5 + kb;
        end else begin
            oa = ra * 5 + kb;
            ob = rb * 5 + ka;
        end
        cipher_q.push_back('{code: square[oa], pair_end: 1'b0});
        cipher_q.push_back('{code: square[ob], pair_end: 1'b1});
    endfunction

    function automatic void encrypt_word(input logic [1:0] cmd,
                                         input logic [LETTER_W-1:0] raw);
        logic [LETTER_W-1:0] l;
        int k;
        l = as_i(raw);
        case (cmd)
            CMD_KEY: begin
                if (raw <= LETTER_LAST) place_letter(l);
            end
            CMD_KEY_DONE: begin
                for (k = 0; k < LETTERS; k++) begin
                    if (5'(k) != LETTER_J) place_letter(5'(k));
                end
            end
            CMD_TEXT: begin
                if (raw <= LETTER_LAST && filled >= CELLS) begin
                    if (!open_valid) begin
                        open_letter = l;
                        open_valid = 1'b1;
                    end else if (open_letter == l) begin
                        // doubled letter: split it, it opens the next pair
                        push_pair(l, pad_for(l));
                    end else begin
                        push_pair(open_letter, l);
                        open_valid = 1'b0;
                    end
                end
            end
            default: begin
                if (filled >= CELLS && open_valid) begin
                    push_pair(open_letter, pad_for(open_letter));
                    open_valid = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic void queue_word(input logic [1:0] c, input logic [LETTER_W-1:0] l);
        word_q.push_back('{cmd: c, letter: l});
        words_left++;
    endfunction

    // mostly text words, with doubles, filler hits, j, bad codes and stray commands
    task automatic random_text(input int count);
        logic [LETTER_W-1:0] prev;
        logic [LETTER_W-1:0] l;
        logic [1:0] c;
        int r;
        prev = '0;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 84) c = CMD_TEXT;
            else if (r < 93) c = CMD_END;
            else if (r < 97) c = CMD_KEY;
            else c = CMD_KEY_DONE;
            r = $urandom_range(0, 99);
            if (r < 15) l = prev;
            else if (r < 22) l = filler_reg;
            else if (r < 25) l = LETTER_Q;
            else if (r < 28) l = LETTER_X;
            else if (r < 31) l = LETTER_J;
            else if (r < 35) l = 5'($urandom_range(26, 31));
            else l = 5'($urandom_range(0, 25));
            queue_word(c, l);
            prev = l;
        end
    endtask

    // key-done sweep is the slowest no-result word, so hold off well past it
    task automatic drain();
        while (words_left != 0 || cipher_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_filler(input logic [LETTER_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        filler_reg = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                encrypt_word(s_cmd, s_letter);
                words_left--;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    next_word = word_q.pop_front();
                    s_cmd    <= next_word.cmd;
                    s_letter <= next_word.letter;
                    s_valid  <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (cipher_q.size() == 0) begin
                    $display("%0t: expected none got %0d/%0d",
                             $realtime, m_cipher_letter, m_pair_end);
                    mismatches++;
                end else if (m_cipher_letter !== cipher_q[0].code
                             || m_pair_end !== cipher_q[0].pair_end) begin
                    $display("%0t: expected %0d/%0d got %0d/%0d", $realtime,
                             cipher_q[0].code, cipher_q[0].pair_end,
                             m_cipher_letter, m_pair_end);
                    mismatches++;
                    void'(cipher_q.pop_front());
                end else begin
                    void'(cipher_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [LETTER_W-1:0] fillers [8];
        int p;
        fillers = '{5'd0, 5'd25, LETTER_Q, LETTER_J, 5'd31, 5'd26, LETTER_I, LETTER_X};

        // text before the square is complete is dropped
        queue_word(CMD_TEXT, 5'd0);
        queue_word(CMD_END, 5'd0);
        // keyword: j lands as i, repeats and bad codes are skipped
        queue_word(CMD_KEY, LETTER_J);
        queue_word(CMD_KEY, 5'd15);
        queue_word(CMD_KEY, 5'd11);
        queue_word(CMD_KEY, 5'd0);
        queue_word(CMD_KEY, 5'd24);
        queue_word(CMD_KEY, 5'd5);
        queue_word(CMD_KEY, LETTER_I);
        queue_word(CMD_KEY, 5'd31);
        queue_word(CMD_KEY, 5'd26);
        queue_word(CMD_KEY, 5'd17);
        queue_word(CMD_KEY, 5'd4);
        queue_word(CMD_KEY, 5'd25);
        repeat ($urandom_range(0, 8)) queue_word(CMD_KEY, 5'($urandom_range(0, 31)));
        queue_word(CMD_KEY_DONE, 5'd0);
        queue_word(CMD_KEY_DONE, 5'd31);
        queue_word(CMD_KEY, 5'd6);
        // doubled filler, j/i doubles, bad code, pads, empty end
        queue_word(CMD_TEXT, LETTER_X);
        queue_word(CMD_TEXT, LETTER_X);
        queue_word(CMD_TEXT, LETTER_J);
        queue_word(CMD_TEXT, LETTER_I);
        queue_word(CMD_TEXT, LETTER_J);
        queue_word(CMD_TEXT, 5'd31);
        queue_word(CMD_END, 5'd0);
        queue_word(CMD_END, 5'd0);
        queue_word(CMD_TEXT, LETTER_Q);
        queue_word(CMD_END, 5'd0);
        queue_word(CMD_TEXT, 5'd0);
        queue_word(CMD_TEXT, 5'd25);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        drain();

        for (p = 0; p < 8; p++) begin
            set_filler(fillers[p]);
            if (p == 7) calm = 1'b1;
            random_text(115);
            drain();
        end

        if (mismatches == 0) begin
            $display("playfair_digraph_encrypt_top_test: clean");
        end else begin
            $display("playfair_digraph_encrypt_top_test: errors");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("playfair_digraph_encrypt_top_test: errors");
        $finish;
    end

endmodule
